>>> src/pvar_pkg.sv
// ----------------------------------------------------------------------------
// pvar_pkg
// Shared widths, the per-set record and the back-end sequencer states.
// ----------------------------------------------------------------------------
package pvar_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 17;
    localparam int SUM_W    = 33;
    localparam int SQS_W    = 48;
    localparam int MEAN_W   = 16;
    localparam int VAR_W    = 32;
    localparam int PROD_W   = 64;
    localparam int DIVR_W   = 33;
    localparam int SQ_LO_W  = 24;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic [SQS_W-1:0]        sumsq;
        logic                    ovf;
    } set_rec_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_MUL_SQ,
        B_MUL_NN,
        B_NUM,
        B_MEAN_GO,
        B_MEAN_WAIT,
        B_VAR_GO,
        B_VAR_WAIT,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic ld_lo;
        logic ld_hi;
        logic ld_sq;
        logic ld_nn;
        logic ld_num;
        logic div_start;
        logic div_sel_var;
        logic ld_mean;
        logic ld_var;
        logic out_load;
    } back_ctrl_t;

endpackage

>>> src/pvar_front.sv
// ----------------------------------------------------------------------------
// pvar_front
// Takes samples, squares them, accumulates count/sum/sum of squares and
// pushes one record per set into the queue on the marked sample.
// ----------------------------------------------------------------------------
module pvar_front #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [pvar_pkg::SAMPLE_W-1:0]    sample,
    input  logic                             last_sample,
    output logic                             push,
    output pvar_pkg::set_rec_t               rec,
    input  logic                             q_full
);
    import pvar_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    logic signed [SAMPLE_BITS-1:0] x_raw;
    logic signed [SAMPLE_W-1:0]    x_ext;
    logic signed [2*SAMPLE_W-1:0]  x_sq;

    logic                        s1_valid_reg, s1_valid_next;
    logic signed [SAMPLE_W-1:0]  s1_x_reg;
    logic [2*SAMPLE_W-1:0]       s1_sq_reg;
    logic                        s1_last_reg;

    logic [CNT_W-1:0]        count_reg, count_next, count_upd;
    logic signed [SUM_W-1:0] sum_reg, sum_next, sum_upd;
    logic [SQS_W-1:0]        sumsq_reg, sumsq_next, sumsq_upd;
    logic                    ovf_reg, ovf_next, ovf_upd;

    logic blocked;
    logic accept;
    logic step;

    assign x_raw    = sample[SAMPLE_BITS-1:0];
    assign x_ext    = SAMPLE_W'(x_raw);
    assign x_sq     = x_ext * x_ext;
    assign blocked  = s1_valid_reg && s1_last_reg && q_full;
    assign in_stall = blocked;
    assign accept   = in_valid && !blocked;
    assign step     = s1_valid_reg && !blocked;

    assign s1_valid_next = blocked ? s1_valid_reg : in_valid;

    always_comb
    begin
        if (count_reg < MAX_CNT)
        begin
            count_upd = count_reg + CNT_W'(1);
            sum_upd   = sum_reg + SUM_W'(s1_x_reg);
            sumsq_upd = sumsq_reg + SQS_W'(s1_sq_reg);
            ovf_upd   = ovf_reg;
        end
        else
        begin
            count_upd = count_reg;
            sum_upd   = sum_reg;
            sumsq_upd = sumsq_reg;
            ovf_upd   = 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        ovf_next   = ovf_reg;
        push       = 1'b0;
        if (step)
        begin
            if (s1_last_reg)
            begin
                push       = 1'b1;
                count_next = '0;
                sum_next   = '0;
                sumsq_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = count_upd;
                sum_next   = sum_upd;
                sumsq_next = sumsq_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    assign rec.count = count_upd;
    assign rec.sum   = sum_upd;
    assign rec.sumsq = sumsq_upd;
    assign rec.ovf   = ovf_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            sumsq_reg    <= sumsq_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= x_ext;
            s1_sq_reg   <= unsigned'(x_sq);
            s1_last_reg <= last_sample;
        end
    end

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("sample count beyond limit");

endmodule

>>> src/pvar_queue.sv
// ----------------------------------------------------------------------------
// pvar_queue
// Two-entry queue of set records between front and back.
// ----------------------------------------------------------------------------
module pvar_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pvar_pkg::set_rec_t   push_rec,
    output logic                 full,
    input  logic                 pop,
    output logic                 q_valid,
    output pvar_pkg::set_rec_t   head
);
    import pvar_pkg::*;

    set_rec_t    entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule

>>> src/pvar_div.sv
// ----------------------------------------------------------------------------
// pvar_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pvar_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pvar_pkg::PROD_W-1:0]   dividend,
    input  logic [pvar_pkg::DIVR_W-1:0]   divisor,
    output logic                          done,
    output logic [pvar_pkg::PROD_W-1:0]   quotient
);
    import pvar_pkg::*;

    localparam int STEP_W = $clog2(PROD_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]   quo_reg, quo_next;
    logic [DIVR_W-1:0]   rem_reg, rem_next;
    logic [DIVR_W-1:0]   dvs_reg, dvs_next;

    logic [DIVR_W:0]     trial;
    logic [DIVR_W+1:0]   diff;
    logic                ge;

    assign trial    = {rem_reg, quo_reg[PROD_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, dvs_reg};
    assign ge       = !diff[DIVR_W+1];
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(PROD_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[PROD_W-2:0], ge};
            rem_next  = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

>>> src/pvar_back.sv
// ----------------------------------------------------------------------------
// pvar_back
// Per-set sequencer: shared multiplier for n*sumsq, sum^2 and n^2, then two
// passes through the iterative divider for mean and variance.
// ----------------------------------------------------------------------------
module pvar_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  pvar_pkg::set_rec_t                head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pvar_pkg::MEAN_W-1:0] mean,
    output logic [pvar_pkg::VAR_W-1:0]        variance,
    output logic [pvar_pkg::CNT_W-1:0]        sample_count,
    output logic                              overflow
);
    import pvar_pkg::*;

    localparam int MUL_W = SUM_W;

    back_state_t state_reg, state_next;
    back_ctrl_t  ctrl;

    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   mul_p;

    logic [CNT_W-1:0]     n_reg;
    logic                 neg_reg;
    logic [SUM_W-1:0]     smag_reg;
    logic [SQS_W-1:0]     sumsq_reg;
    logic                 ovf_reg;
    logic [PROD_W-1:0]    nsq_reg;
    logic [PROD_W-1:0]    hi_reg;
    logic [PROD_W-1:0]    sq_reg;
    logic [DIVR_W-1:0]    nn_reg;
    logic [PROD_W-1:0]    num_reg;
    logic [MEAN_W-1:0]    mean_q_reg;
    logic [VAR_W-1:0]     var_q_reg;

    logic [SUM_W-1:0]     head_sum_u;
    logic [SUM_W-1:0]     head_smag;
    logic [PROD_W:0]      num_diff;

    logic                 div_done;
    logic [PROD_W-1:0]    div_quo;
    logic [PROD_W-1:0]    div_dividend;
    logic [DIVR_W-1:0]    div_divisor;

    logic                 out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0]    mean_reg;
    logic [VAR_W-1:0]     var_reg;
    logic [CNT_W-1:0]     cnt_out_reg;
    logic                 ovf_out_reg;

    assign head_sum_u = unsigned'(head.sum);
    assign head_smag  = head_sum_u[SUM_W-1] ? (~head_sum_u + SUM_W'(1)) : head_sum_u;
    assign num_diff   = {1'b0, nsq_reg} - {1'b0, sq_reg};
    assign mul_p      = mul_a * mul_b;

    assign div_dividend = ctrl.div_sel_var ? num_reg : PROD_W'(smag_reg);
    assign div_divisor  = ctrl.div_sel_var ? nn_reg : DIVR_W'(n_reg);

    pvar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:      if (q_valid) state_next = B_MUL_LO;
            B_MUL_LO:    state_next = B_MUL_HI;
            B_MUL_HI:    state_next = B_MUL_SQ;
            B_MUL_SQ:    state_next = B_MUL_NN;
            B_MUL_NN:    state_next = B_NUM;
            B_NUM:       state_next = B_MEAN_GO;
            B_MEAN_GO:   state_next = B_MEAN_WAIT;
            B_MEAN_WAIT: if (div_done) state_next = B_VAR_GO;
            B_VAR_GO:    state_next = B_VAR_WAIT;
            B_VAR_WAIT:  if (div_done) state_next = B_DONE;
            B_DONE:      if (!out_valid_reg || !out_stall) state_next = B_IDLE;
            default:     state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl  = '0;
        mul_a = MUL_W'(n_reg);
        mul_b = MUL_W'(n_reg);
        case (state_reg)
            B_IDLE:
            begin
                ctrl.pop = q_valid;
            end
            B_MUL_LO:
            begin
                ctrl.ld_lo = 1'b1;
                mul_b      = MUL_W'(sumsq_reg[SQ_LO_W-1:0]);
            end
            B_MUL_HI:
            begin
                ctrl.ld_hi = 1'b1;
                mul_b      = MUL_W'(sumsq_reg[SQS_W-1:SQ_LO_W]);
            end
            B_MUL_SQ:
            begin
                ctrl.ld_sq = 1'b1;
                mul_a      = smag_reg;
                mul_b      = smag_reg;
            end
            B_MUL_NN:
            begin
                ctrl.ld_nn = 1'b1;
            end
            B_NUM:
            begin
                ctrl.ld_num = 1'b1;
            end
            B_MEAN_GO:
            begin
                ctrl.div_start = 1'b1;
            end
            B_MEAN_WAIT:
            begin
                ctrl.ld_mean = div_done;
            end
            B_VAR_GO:
            begin
                ctrl.div_start   = 1'b1;
                ctrl.div_sel_var = 1'b1;
            end
            B_VAR_WAIT:
            begin
                ctrl.div_sel_var = 1'b1;
                ctrl.ld_var      = div_done;
            end
            B_DONE:
            begin
                ctrl.out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign pop            = ctrl.pop;
    assign out_valid_next = ctrl.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pop)
        begin
            n_reg     <= head.count;
            neg_reg   <= head_sum_u[SUM_W-1];
            smag_reg  <= head_smag;
            sumsq_reg <= head.sumsq;
            ovf_reg   <= head.ovf;
        end
        if (ctrl.ld_lo)
        begin
            nsq_reg <= mul_p[PROD_W-1:0];
        end
        if (ctrl.ld_hi)
        begin
            hi_reg <= mul_p[PROD_W-1:0];
        end
        if (ctrl.ld_sq)
        begin
            sq_reg <= mul_p[PROD_W-1:0];
        end
        if (ctrl.ld_nn)
        begin
            nn_reg  <= mul_p[DIVR_W-1:0];
            nsq_reg <= nsq_reg + {hi_reg[PROD_W-SQ_LO_W-1:0], {SQ_LO_W{1'b0}}};
        end
        if (ctrl.ld_num)
        begin
            num_reg <= num_diff[PROD_W] ? '0 : num_diff[PROD_W-1:0];
        end
        if (ctrl.ld_mean)
        begin
            mean_q_reg <= neg_reg ? (~div_quo[MEAN_W-1:0] + MEAN_W'(1))
                                  : div_quo[MEAN_W-1:0];
        end
        if (ctrl.ld_var)
        begin
            var_q_reg <= div_quo[VAR_W-1:0];
        end
        if (ctrl.out_load)
        begin
            mean_reg    <= mean_q_reg;
            var_reg     <= var_q_reg;
            cnt_out_reg <= n_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mean         = signed'(mean_reg);
    assign variance     = var_reg;
    assign sample_count = cnt_out_reg;
    assign overflow     = ovf_out_reg;

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == B_MEAN_WAIT || state_reg == B_VAR_WAIT))
        else $error("divider finished outside a wait state");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten before taken");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

>>> src/population_variance_top.sv
// Throughput: one sample per cycle while in_stall is low; results per set are paced
// by two 64-step passes through the shared iterative divider.
// A two-entry record queue lets samples keep flowing while the back end works.
// Reset (rst_n, async, active low) clears sums, count, queue and sequencer.
// ----------------------------------------------------------------------------
// population_variance_top
// Streaming population mean and variance of signed Q8.8 samples.
// ----------------------------------------------------------------------------
module population_variance_top #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [pvar_pkg::SAMPLE_W-1:0] sample,
    input  logic                               last_sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pvar_pkg::MEAN_W-1:0] mean,
    output logic [pvar_pkg::VAR_W-1:0]         variance,
    output logic [pvar_pkg::CNT_W-1:0]         sample_count,
    output logic                               overflow
);
    import pvar_pkg::*;

    logic     push;
    set_rec_t push_rec;
    logic     q_full;
    logic     pop;
    logic     q_valid;
    set_rec_t head;

    pvar_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (unsigned'(sample)),
        .last_sample (last_sample),
        .push        (push),
        .rec         (push_rec),
        .q_full      (q_full)
    );

    pvar_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    pvar_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean         (mean),
        .variance     (variance),
        .sample_count (sample_count),
        .overflow     (overflow)
    );

endmodule

>>> tb/sv/population_variance_top_test.sv
// ----------------------------------------------------------------------------
// population_variance_top_test
// Self-checking bench for the streaming mean/variance block. A queue-fed
// driver offers sample words in random bursts, a predictor folds each
// accepted word into its own sums and queues the per-set statistics, and a
// monitor with its own stall pattern checks every result word against them.
// Covers single-sample and extreme sets, truncation of negative means and
// random sets of mixed length.
// ----------------------------------------------------------------------------
module population_variance_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pvar_pkg::*;

    localparam int MAX_SAMPLES  = 65536;
    localparam int SAMPLE_BITS  = 16;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } sample_word_t;

    typedef struct {
        logic signed [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]         variance;
        logic [CNT_W-1:0]         count;
        logic                     ovf;
    } set_stats_t;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;
    typedef enum int {VAL_ANY, VAL_NEAR, VAL_EDGE} val_style_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  sample = '0;
    logic                        last_sample = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [MEAN_W-1:0]    mean;
    logic [VAR_W-1:0]            variance;
    logic [CNT_W-1:0]            sample_count;
    logic                        overflow;

    sample_word_t sample_feed[$];
    set_stats_t   set_stats_q[$];

    int unsigned     acc_count;
    longint          acc_sum;
    longint unsigned acc_sumsq;
    bit              acc_ovf;

    int           words_total;
    int           words_accepted;
    int           err_count;
    int           cycle_count;
    int           hold_requests;
    int           hold_served;
    int           hold_left;
    int           burst_left;
    int           gap_left;
    int           mode_left;
    rx_mode_t     rx_mode;
    sample_word_t next_word;
    logic         stall_next;
    set_stats_t   want;

    population_variance_top #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean         (mean),
        .variance     (variance),
        .sample_count (sample_count),
        .overflow     (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_set_stats(input logic [SAMPLE_W-1:0] raw,
                                              input logic last);
        longint          x;
        longint unsigned mag;
        longint unsigned n;
        longint unsigned smag;
        longint unsigned q;
        longint unsigned sq;
        longint unsigned nsq;
        longint unsigned num;
        longint unsigned vq;
        set_stats_t      s;
        x = raw & ((64'd1 << SAMPLE_BITS) - 1);
        if (x >= (64'sd1 << (SAMPLE_BITS - 1)))
            x = x - (64'sd1 << SAMPLE_BITS);
        if (acc_count < MAX_SAMPLES)
        begin
            mag = (x < 0) ? -x : x;
            acc_count++;
            acc_sum   += x;
            acc_sumsq += mag * mag;
        end
        else
            acc_ovf = 1'b1;
        if (last)
        begin
            n    = acc_count;
            smag = (acc_sum < 0) ? -acc_sum : acc_sum;
            q    = smag / n;
            sq   = smag * smag;
            nsq  = n * acc_sumsq;
            num  = (nsq >= sq) ? nsq - sq : 0;
            vq   = num / (n * n);
            s.mean     = MEAN_W'((acc_sum < 0) ? -q : q);
            s.variance = vq[VAR_W-1:0];
            s.count    = n[CNT_W-1:0];
            s.ovf      = acc_ovf;
            set_stats_q.push_back(s);
            acc_count = 0;
            acc_sum   = 0;
            acc_sumsq = 0;
            acc_ovf   = 1'b0;
        end
    endfunction

    task automatic push_word(input logic [SAMPLE_W-1:0] v, input logic last);
        sample_word_t w;
        w.sample = v;
        w.last   = last;
        sample_feed.push_back(w);
        words_total++;
    endtask

    // driver: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            sample      <= '0;
            last_sample <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_set_stats(sample, last_sample);
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (sample_feed.size() > 0)
                begin
                    next_word = sample_feed.pop_front();
                    in_valid    <= 1'b1;
                    sample      <= next_word.sample;
                    last_sample <= next_word.last;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 31);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks result words, drives its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_served = 0;
            hold_left   = 0;
            mode_left   = 0;
            rx_mode     = RX_FREE;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (set_stats_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result word mean=%0d variance=%0d count=%0d ovf=%0b",
                             $time, mean, variance, sample_count, overflow);
                end
                else
                begin
                    want = set_stats_q.pop_front();
                    if (mean !== want.mean)
                    begin
                        err_count++;
                        $display("%0t: mean expected %0d actual %0d", $time, want.mean, mean);
                    end
                    if (variance !== want.variance)
                    begin
                        err_count++;
                        $display("%0t: variance expected %0d actual %0d",
                                 $time, want.variance, variance);
                    end
                    if (sample_count !== want.count)
                    begin
                        err_count++;
                        $display("%0t: sample_count expected %0d actual %0d",
                                 $time, want.count, sample_count);
                    end
                    if (overflow !== want.ovf)
                    begin
                        err_count++;
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, want.ovf, overflow);
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 600);
                end
                else
                    mode_left--;
                case (rx_mode)
                    RX_FREE:  stall_next = 1'b0;
                    RX_LIGHT: stall_next = ($urandom_range(0, 7) == 0);
                    RX_HALF:  stall_next = 1'($urandom_range(0, 1));
                    default:  stall_next = ($urandom_range(0, 7) != 0);
                endcase
            end
            out_stall <= stall_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("population_variance_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        int          len;
        int          random_items;
        logic [15:0] base;
        logic [15:0] v;
        val_style_t  style;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_word(16'h7FFF, 1'b1);
        push_word(16'h8000, 1'b1);
        push_word(16'h7FFF, 1'b0);
        push_word(16'h8000, 1'b1);
        push_word(-16'sd3, 1'b0);   // negative mean truncates toward zero
        push_word(16'h0000, 1'b1);
        push_word(16'h0000, 1'b1);
        push_word(16'h0005, 1'b0);
        push_word(16'h0007, 1'b0);
        push_word(16'hFFFE, 1'b0);
        push_word(16'h1964, 1'b1);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0001, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0001, 1'b1);
        push_word(16'h0064, 1'b1);

        while (!(words_accepted == words_total && set_stats_q.size() == 0))
            @(posedge clk);

        hold_requests++;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(1, 4);
                4, 5, 6, 7: len = $urandom_range(5, 16);
                8:          len = $urandom_range(17, 64);
                default:    len = $urandom_range(65, 200);
            endcase
            style = val_style_t'($urandom_range(0, 2));
            base  = 16'($urandom);
            for (int i = 0; i < len; i++)
            begin
                case (style)
                    VAL_ANY:  v = 16'($urandom);
                    VAL_NEAR: v = 16'(base + $urandom_range(0, 511) - 256);
                    default:
                        case ($urandom_range(0, 4))
                            0:       v = 16'h8000;
                            1:       v = 16'h7FFF;
                            2:       v = 16'h0000;
                            3:       v = 16'hFFFF;
                            default: v = 16'h0001;
                        endcase
                endcase
                push_word(v, i == len - 1);
            end
            random_items += len;
        end

        while (!(words_accepted == words_total && set_stats_q.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("population_variance_top regression: pass");
        else
            $display("population_variance_top regression: fail");
        $finish;
    end

endmodule
